### src/spm_pkg.sv
`timescale 1ns / 1ps
// spm_pkg: shared types and constants for the spectral projection block
// no dependencies

package spm_pkg;

    // fixed field and datapath widths
    localparam int COEF_W = 16;
    localparam int ACC_W  = 48;
    localparam int OUT_W  = 32;
    localparam int COMP_W = 4;
    localparam int BAND_W = 8;
    localparam int CFG_W  = 9;

    // configuration register indexes
    localparam logic [1:0] CFG_BANDS_IN_USE      = 2'd0;
    localparam logic [1:0] CFG_COMPONENTS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_FRAC_SHIFT        = 2'd2;

    // configuration reset values
    localparam logic [8:0] RST_BANDS_IN_USE      = 9'd256;
    localparam logic [4:0] RST_COMPONENTS_IN_USE = 5'd16;
    localparam logic [3:0] RST_FRAC_SHIFT        = 4'd15;

    // input item modes
    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // saturation limits, sized for the negated shifted sum
    localparam logic signed [ACC_W:0] SAT_MAX = 49'sd2147483647;
    localparam logic signed [ACC_W:0] SAT_MIN = -49'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_WB,
        ST_EMIT_RD,
        ST_EMIT_SH,
        ST_EMIT_OUT
    } t_spm_state;

    typedef struct packed {
        logic sample_ld;
        logic mul_en;
        logic acc_we;
        logic acc_clr;
        logic shift_en;
        logic out_load;
        logic out_last;
    } t_spm_ctl;

endpackage

### src/spm_coef_ram.sv
`timescale 1ns / 1ps
// spm_coef_ram: coefficient matrix storage, one write and one registered read port
// depends on spm_pkg

module spm_coef_ram
    import spm_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [COEF_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [COEF_W-1:0] o_rdata
);

    logic [COEF_W-1:0] r_mem [DEPTH];
    logic [COEF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/spm_acc_ram.sv
`timescale 1ns / 1ps
// spm_acc_ram: per-component accumulator memory with valid bits for bulk clear
// depends on spm_pkg

module spm_acc_ram
    import spm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [AW-1:0]           i_addr,
    input  logic                    i_we,
    input  logic                    i_clr,
    input  logic signed [ACC_W-1:0] i_wdata,
    output logic signed [ACC_W-1:0] o_rdata
);

    logic signed [ACC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_valid;
    logic signed [ACC_W-1:0] r_rdata;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    // an entry that is not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= r_valid[i_addr];
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

### src/spm_datapath.sv
`timescale 1ns / 1ps
// spm_datapath: multiply-accumulate and result shaping (shift, negate, saturate)
// depends on spm_pkg

module spm_datapath
    import spm_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  t_spm_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_value,
    input  logic [COEF_W-1:0]             i_coef,
    input  logic signed [ACC_W-1:0]       i_acc,
    input  logic [3:0]                    i_frac_shift,
    output logic signed [ACC_W-1:0]       o_acc_wdata,
    output logic signed [OUT_W-1:0]       o_projected
);

    localparam int PW = COEF_W + SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACC_W-1:0]       r_acc_q;
    logic signed [ACC_W-1:0]       r_shift;
    logic signed [ACC_W:0]         neg;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample_ld) begin
            r_sample <= i_value;
        end
        if (i_ctl.mul_en) begin
            r_prod  <= $signed(i_coef) * r_sample;
            r_acc_q <= i_acc;
        end
        if (i_ctl.shift_en) begin
            r_shift <= i_acc >>> i_frac_shift;
        end
    end

    // sum wraps at the accumulator width
    assign o_acc_wdata = r_acc_q + ACC_W'(r_prod);

    assign neg = -(ACC_W+1)'(r_shift);

    always_comb begin
        if (neg > SAT_MAX) begin
            o_projected = OUT_W'(SAT_MAX);
        end else if (neg < SAT_MIN) begin
            o_projected = OUT_W'(SAT_MIN);
        end else begin
            o_projected = OUT_W'(neg);
        end
    end

endmodule

### src/spm_seq.sv
`timescale 1ns / 1ps
// spm_seq: sequencer that walks the components of each transaction over the memories
// depends on spm_pkg

module spm_seq
    import spm_pkg::*;
#(
    parameter int MAX_BANDS      = 256,
    parameter int MAX_COMPONENTS = 16,
    parameter int AW             = 12,
    parameter int CI_W           = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [COMP_W-1:0] i_component_index,
    input  logic [BAND_W-1:0] i_band_index,
    input  logic [8:0]        i_bands_in_use,
    input  logic [4:0]        i_components_in_use,
    input  logic              i_out_free,
    output logic              o_coef_we,
    output logic [AW-1:0]     o_coef_waddr,
    output logic [AW-1:0]     o_coef_raddr,
    output logic [CI_W-1:0]   o_acc_addr,
    output logic [COMP_W-1:0] o_component,
    output t_spm_ctl          o_ctl
);

    localparam int BI_W   = $clog2(MAX_BANDS);
    localparam int BC_W   = $clog2(MAX_BANDS + 1);
    localparam int NB_W   = (BC_W > CFG_W) ? BC_W : CFG_W;
    localparam int NC_CLG = $clog2(MAX_COMPONENTS + 1);
    localparam int NC_W   = (NC_CLG > 5) ? NC_CLG : 5;

    t_spm_state      r_state, n_state;
    logic [BC_W-1:0] r_band_count;
    logic [CI_W-1:0] r_comp;
    logic [NC_W-1:0] r_nc;
    logic            r_last_band;

    logic            accept;
    logic            take_sample;
    logic            acc_en;
    logic            last_now;
    logic            comp_last;
    logic [NB_W-1:0] nb_raw;
    logic [NB_W-1:0] nb_eff;
    logic [NC_W-1:0] nc_raw;
    logic [NC_W-1:0] nc_eff;
    logic            coef_in_range;

    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign take_sample = accept && (i_mode == MODE_SAMPLE);

    // register values outside their range are clamped
    assign nb_raw = NB_W'(i_bands_in_use);
    assign nb_eff = (nb_raw == '0) ? NB_W'(1) :
                    (nb_raw > NB_W'(MAX_BANDS)) ? NB_W'(MAX_BANDS) : nb_raw;
    assign nc_raw = NC_W'(i_components_in_use);
    assign nc_eff = (nc_raw == '0) ? NC_W'(1) :
                    (nc_raw > NC_W'(MAX_COMPONENTS)) ? NC_W'(MAX_COMPONENTS) : nc_raw;

    assign acc_en    = (r_band_count < BC_W'(MAX_BANDS));
    assign last_now  = ((NB_W'(r_band_count) + NB_W'(1)) >= nb_eff);
    assign comp_last = ((NC_W'(r_comp) + NC_W'(1)) == r_nc);

    assign coef_in_range = (32'(i_component_index) < 32'(MAX_COMPONENTS)) &&
                           (32'(i_band_index) < 32'(MAX_BANDS));

    assign o_coef_we    = accept && (i_mode == MODE_COEF) && coef_in_range;
    assign o_coef_waddr = AW'(i_component_index) * AW'(MAX_BANDS) + AW'(i_band_index);
    assign o_coef_raddr = AW'(r_comp) * AW'(MAX_BANDS) + AW'(r_band_count[BI_W-1:0]);
    assign o_acc_addr   = r_comp;
    assign o_component  = COMP_W'(r_comp);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take_sample) begin
                    if (acc_en) begin
                        n_state = ST_MAC_RD;
                    end else if (last_now) begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_MAC_RD:  n_state = ST_MAC_MUL;
            ST_MAC_MUL: n_state = ST_MAC_WB;
            ST_MAC_WB: begin
                if (!comp_last) begin
                    n_state = ST_MAC_RD;
                end else if (r_last_band) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: n_state = ST_EMIT_SH;
            ST_EMIT_SH: n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (i_out_free) begin
                    n_state = comp_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        case (r_state)
            ST_IDLE:    o_ctl.sample_ld = take_sample;
            ST_MAC_MUL: o_ctl.mul_en = 1'b1;
            ST_MAC_WB:  o_ctl.acc_we = 1'b1;
            ST_EMIT_SH: o_ctl.shift_en = 1'b1;
            ST_EMIT_OUT: begin
                o_ctl.out_load = i_out_free;
                o_ctl.out_last = comp_last;
                o_ctl.acc_clr  = i_out_free && comp_last;
            end
            default: o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_band_count <= '0;
            r_comp       <= '0;
            r_nc         <= NC_W'(1);
            r_last_band  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (take_sample) begin
                        r_comp      <= '0;
                        r_nc        <= nc_eff;
                        r_last_band <= last_now;
                        if (!acc_en && !last_now) begin
                            r_band_count <= r_band_count + BC_W'(1);
                        end
                    end
                end
                ST_MAC_WB: begin
                    if (comp_last) begin
                        r_comp <= '0;
                        if (!r_last_band) begin
                            r_band_count <= r_band_count + BC_W'(1);
                        end
                    end else begin
                        r_comp <= r_comp + CI_W'(1);
                    end
                end
                ST_EMIT_OUT: begin
                    if (i_out_free) begin
                        if (comp_last) begin
                            r_band_count <= '0;
                        end else begin
                            r_comp <= r_comp + CI_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### src/spectral_projection_mac.sv
`timescale 1ns / 1ps
// spectral_projection_mac: top level, configuration registers and result register
// depends on spm_pkg, spm_coef_ram, spm_acc_ram, spm_datapath, spm_seq
//
// Input channel (i_valid / o_stall) carries one transaction per coefficient load or
// band sample. A coefficient load (mode 0) does not raise o_stall, so the next
// transaction can follow in the next cycle. A band sample (mode 1) is taken, and
// then each of the N components in use does a coefficient and accumulator read,
// a registered multiply, then an accumulator write-back through the single port
// of the accumulator memory.
// On the last band of a pixel the block then emits N result transactions on the
// output channel (o_valid / i_stall) in turn, each by an accumulator read, a
// registered shift, then negate and saturate into the result register. o_last
// marks the final component. While the receiver stalls, the result register holds
// and the block waits; o_stall stays high until the whole pixel is sent, and
// the accumulators then read as zero for the next pixel.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) must be written only while
// idle; the block does not enforce this. Reset is synchronous: registers return
// to 256 bands, 16 components, shift 15, band count and accumulators cleared.
// Coefficients are not cleared and must be loaded before use.

module spectral_projection_mac
    import spm_pkg::*;
#(
    parameter int MAX_BANDS      = 256,
    parameter int MAX_COMPONENTS = 16,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [COMP_W-1:0]             i_component_index,
    input  logic [BAND_W-1:0]             i_band_index,
    input  logic signed [SAMPLE_BITS-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COMP_W-1:0]             o_component,
    output logic signed [OUT_W-1:0]       o_projected,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    localparam int DEPTH = MAX_COMPONENTS * MAX_BANDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CI_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    logic [8:0] r_bands_in_use;
    logic [4:0] r_components_in_use;
    logic [3:0] r_frac_shift;

    logic                    r_out_valid;
    logic [COMP_W-1:0]       r_out_component;
    logic signed [OUT_W-1:0] r_out_projected;
    logic                    r_out_last;

    t_spm_ctl                ctl;
    logic                    out_free;
    logic                    coef_we;
    logic [AW-1:0]           coef_waddr;
    logic [AW-1:0]           coef_raddr;
    logic [COEF_W-1:0]       coef_wdata;
    logic [COEF_W-1:0]       coef_rdata;
    logic [CI_W-1:0]         acc_addr;
    logic signed [ACC_W-1:0] acc_rdata;
    logic signed [ACC_W-1:0] acc_wdata;
    logic [COMP_W-1:0]       seq_component;
    logic signed [OUT_W-1:0] projected;

    // coefficient takes the low 16 bits of the value field, zero-extended if narrower
    generate
        if (SAMPLE_BITS >= COEF_W) begin : g_coef_trunc
            assign coef_wdata = i_value[COEF_W-1:0];
        end else begin : g_coef_ext
            assign coef_wdata = {{(COEF_W - SAMPLE_BITS){1'b0}}, i_value};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands_in_use      <= RST_BANDS_IN_USE;
            r_components_in_use <= RST_COMPONENTS_IN_USE;
            r_frac_shift        <= RST_FRAC_SHIFT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BANDS_IN_USE:      r_bands_in_use <= i_cfg_data;
                CFG_COMPONENTS_IN_USE: r_components_in_use <= i_cfg_data[4:0];
                CFG_FRAC_SHIFT:        r_frac_shift <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    spm_seq #(
        .MAX_BANDS      (MAX_BANDS),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .AW             (AW),
        .CI_W           (CI_W)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_component_index   (i_component_index),
        .i_band_index        (i_band_index),
        .i_bands_in_use      (r_bands_in_use),
        .i_components_in_use (r_components_in_use),
        .i_out_free          (out_free),
        .o_coef_we           (coef_we),
        .o_coef_waddr        (coef_waddr),
        .o_coef_raddr        (coef_raddr),
        .o_acc_addr          (acc_addr),
        .o_component         (seq_component),
        .o_ctl               (ctl)
    );

    spm_coef_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    spm_acc_ram #(
        .DEPTH (MAX_COMPONENTS),
        .AW    (CI_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (acc_addr),
        .i_we    (ctl.acc_we),
        .i_clr   (ctl.acc_clr),
        .i_wdata (acc_wdata),
        .o_rdata (acc_rdata)
    );

    spm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_value      (i_value),
        .i_coef       (coef_rdata),
        .i_acc        (acc_rdata),
        .i_frac_shift (r_frac_shift),
        .o_acc_wdata  (acc_wdata),
        .o_projected  (projected)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out_component <= seq_component;
            r_out_projected <= projected;
            r_out_last      <= ctl.out_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_component = r_out_component;
    assign o_projected = r_out_projected;
    assign o_last      = r_out_last;

endmodule
